[hdl/d64ems_pkg.sv]
// Package for the disk image error map scanner.
// Holds the error byte codes, finding codes, zone geometry and the decode helpers.
// No dependencies; imported by the core and its checker.
package d64ems_pkg;

    localparam int unsigned MAX_TRACKS = 42;

    localparam int unsigned BLOCK_W  = 10;
    localparam int unsigned TRACK_W  = 6;
    localparam int unsigned SECTOR_W = 5;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CODE_W   = 3;

    localparam logic [BLOCK_W-1:0]  BLOCK_INDEX_MAX   = 10'd1023;
    localparam logic [BLOCK_W-1:0]  DISK_BLOCKS_RESET = 10'd683;
    localparam logic [TRACK_W-1:0]  TRACK_FIRST       = 6'd1;
    localparam logic [TRACK_W-1:0]  TRACK_LAST        = 6'(MAX_TRACKS);

    // Error map byte values that produce a finding
    localparam logic [BYTE_W-1:0] BYTE_NO_HEADER   = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_NO_SYNC     = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_NO_DATA     = 8'h04;
    localparam logic [BYTE_W-1:0] BYTE_DATA_SUM    = 8'h05;
    localparam logic [BYTE_W-1:0] BYTE_HEADER_SUM  = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_ID_MISMATCH = 8'h0B;

    typedef enum logic [CODE_W-1:0] {
        FIND_NO_HEADER   = 3'd0,
        FIND_NO_SYNC     = 3'd1,
        FIND_NO_DATA     = 3'd2,
        FIND_DATA_SUM    = 3'd3,
        FIND_HEADER_FLT  = 3'd4
    } finding_t;

    typedef struct packed {
        logic     hit;
        finding_t code;
    } class_t;

    // Speed zones: 21, 19, 18 and 17 sectors per track
    function automatic logic [SECTOR_W-1:0] sectors_on_track(input logic [TRACK_W-1:0] trk);
        logic [SECTOR_W-1:0] n;
        if (trk <= 6'd17) begin
            n = 5'd21;
        end else if (trk <= 6'd24) begin
            n = 5'd19;
        end else if (trk <= 6'd30) begin
            n = 5'd18;
        end else begin
            n = 5'd17;
        end
        return n;
    endfunction

    function automatic class_t classify(input logic [BYTE_W-1:0] b);
        class_t c;
        c.hit  = 1'b1;
        c.code = FIND_NO_HEADER;
        unique case (b) inside
            BYTE_NO_HEADER:   c.code = FIND_NO_HEADER;
            BYTE_NO_SYNC:     c.code = FIND_NO_SYNC;
            BYTE_NO_DATA:     c.code = FIND_NO_DATA;
            BYTE_DATA_SUM:    c.code = FIND_DATA_SUM;
            BYTE_HEADER_SUM,
            BYTE_ID_MISMATCH: c.code = FIND_HEADER_FLT;
            default:          c.hit  = 1'b0;
        endcase
        return c;
    endfunction

endpackage

[hdl/d64_error_map_scanner_core.sv]
// Error map scanner core: walks block/track/sector and reports faulty blocks.
// Depends on d64ems_pkg for codes, zone geometry and the byte decoder.
//
// Usage:
//   Input channel (s_valid/s_ready): one error map byte per request, in
//   block order. Raise s_start_of_map with the byte of block zero to restart
//   the track and sector count at track 1, sector 0.
//   Result channel (m_valid/m_ready): one request per faulty block, carrying
//   the finding code, track, sector and the raw byte. OK bytes, write-side
//   errors, unknown bytes, blocks at or past disk_blocks and blocks past the
//   last track give no request.
//   Configuration: cfg_wr_en writes cfg_wr_data into disk_blocks at once.
//   Write it only while no request is in flight.
// Timing:
//   One input request per cycle while s_ready is high. A finding appears
//   on the result port in the cycle after its byte is taken. The counters
//   and the decoder sit between the input handshake and the single result
//   register, so throughput is one byte per cycle as long as it drains.
// Reset and stall:
//   Synchronous active-low reset clears the result valid flag, sets
//   disk_blocks to 683 and the position to block 0, track 1, sector 0.
//   While a result waits and m_ready is low, s_ready drops; a byte that
//   yields no finding is still taken only when the result register can load.
module d64_error_map_scanner_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [d64ems_pkg::BLOCK_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [d64ems_pkg::BYTE_W-1:0]     s_error_byte,
    input  logic                              s_start_of_map,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [d64ems_pkg::CODE_W-1:0]     m_finding_code,
    output logic [d64ems_pkg::TRACK_W-1:0]    m_track,
    output logic [d64ems_pkg::SECTOR_W-1:0]   m_sector,
    output logic [d64ems_pkg::BYTE_W-1:0]     m_raw_error
);
    import d64ems_pkg::*;

    // Configuration and position state
    logic [BLOCK_W-1:0]  disk_blocks_reg;
    logic [BLOCK_W-1:0]  block_index_reg,  block_index_next;
    logic [TRACK_W-1:0]  track_reg,        track_next;
    logic [SECTOR_W-1:0] sector_reg,       sector_next;

    // Result register
    logic                m_valid_reg,      m_valid_next;
    finding_t            code_reg;
    logic [TRACK_W-1:0]  m_track_reg;
    logic [SECTOR_W-1:0] m_sector_reg;
    logic [BYTE_W-1:0]   raw_reg;

    logic                accept;
    logic                load;
    logic [BLOCK_W-1:0]  idx_eff;
    logic [TRACK_W-1:0]  trk_eff;
    logic [SECTOR_W-1:0] sec_eff;
    logic [SECTOR_W-1:0] sec_inc;
    class_t              cls;
    logic                hit;

    // Take a new byte whenever the result register is empty or being drained
    assign load    = !m_valid_reg || m_ready;
    assign s_ready = load;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // Start flag restarts the count before the byte is judged
        idx_eff = s_start_of_map ? '0          : block_index_reg;
        trk_eff = s_start_of_map ? TRACK_FIRST : track_reg;
        sec_eff = s_start_of_map ? '0          : sector_reg;

        cls = classify(s_error_byte);
        hit = cls.hit && (idx_eff < disk_blocks_reg)
            && (trk_eff >= TRACK_FIRST) && (trk_eff <= TRACK_LAST);

        // Saturate the block index
        block_index_next = (idx_eff < BLOCK_INDEX_MAX) ? idx_eff + 10'd1 : idx_eff;

        // Advance sector and track; hold once past the last track
        sec_inc     = sec_eff + 5'd1;
        track_next  = trk_eff;
        sector_next = sec_eff;
        if (trk_eff <= TRACK_LAST) begin
            if (sec_inc >= sectors_on_track(trk_eff)) begin
                sector_next = '0;
                track_next  = trk_eff + 6'd1;
            end else begin
                sector_next = sec_inc;
            end
        end

        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = accept && hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_blocks_reg <= DISK_BLOCKS_RESET;
            block_index_reg <= '0;
            track_reg       <= TRACK_FIRST;
            sector_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                disk_blocks_reg <= cfg_wr_data;
            end
            if (accept) begin
                block_index_reg <= block_index_next;
                track_reg       <= track_next;
                sector_reg      <= sector_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload: load with the finding, hold while stalled
    always_ff @(posedge aclk) begin
        if (accept && hit) begin
            code_reg     <= cls.code;
            m_track_reg  <= trk_eff;
            m_sector_reg <= sec_eff;
            raw_reg      <= s_error_byte;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_finding_code = code_reg;
    assign m_track        = m_track_reg;
    assign m_sector       = m_sector_reg;
    assign m_raw_error    = raw_reg;

endmodule

[hdl/d64ems_checker.sv]
// Port-level checker for the error map scanner core, with its bind.
// Depends on d64ems_pkg for byte and finding codes and the zone geometry.
module d64ems_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [d64ems_pkg::CODE_W-1:0]     m_finding_code,
    input logic [d64ems_pkg::TRACK_W-1:0]    m_track,
    input logic [d64ems_pkg::SECTOR_W-1:0]   m_sector,
    input logic [d64ems_pkg::BYTE_W-1:0]     m_raw_error
);
    import d64ems_pkg::*;

    // Hold a stalled result with its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_finding_code) && $stable(m_track)
            && $stable(m_sector) && $stable(m_raw_error))
        else $error("stalled result changed");

    // Code must agree with the raw byte
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_finding_code == FIND_NO_HEADER  && m_raw_error == BYTE_NO_HEADER) ||
            (m_finding_code == FIND_NO_SYNC    && m_raw_error == BYTE_NO_SYNC) ||
            (m_finding_code == FIND_NO_DATA    && m_raw_error == BYTE_NO_DATA) ||
            (m_finding_code == FIND_DATA_SUM   && m_raw_error == BYTE_DATA_SUM) ||
            (m_finding_code == FIND_HEADER_FLT &&
                (m_raw_error == BYTE_HEADER_SUM || m_raw_error == BYTE_ID_MISMATCH)))
        else $error("finding code does not match raw byte");

    // Position lies on the disk geometry
    a_geom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_track >= TRACK_FIRST && m_track <= TRACK_LAST
            && m_sector < sectors_on_track(m_track))
        else $error("finding outside disk geometry");

    // Empty result register never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Reset drops the result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind d64_error_map_scanner_core d64ems_checker u_d64ems_checker (.*);
